### sv/rec_pkg.sv
// ----------------------------------------------------------------------------
// rec_pkg
// shared types, constants and the quadrature transition table for the
// rotary encoder with click detection
// ----------------------------------------------------------------------------
package rec_pkg;

    localparam int ELAPSED_BITS_DEF = 16;

    localparam logic [7:0]  DETENT_COUNT_RST     = 8'd4;
    localparam logic [7:0]  ROTATION_LOCKOUT_RST = 8'd2;
    localparam logic [15:0] DEBOUNCE_TIME_RST    = 16'd20;
    localparam logic [15:0] CLICK_WINDOW_RST     = 16'd300;

    localparam logic [7:0] ROT_ELAPSED_MAX = 8'hFF;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DETENT_COUNT     = 2'd0,
        REG_ROTATION_LOCKOUT = 2'd1,
        REG_DEBOUNCE_TIME    = 2'd2,
        REG_CLICK_WINDOW     = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2
    } button_event_t;

    localparam logic signed [1:0] STEP_NONE = 2'sd0;
    localparam logic signed [1:0] STEP_CW   = 2'sd1;
    localparam logic signed [1:0] STEP_CCW  = -2'sd1;

    typedef struct packed {
        logic accept;
        logic first;
    } tick_ctl_t;

    // index is {old phase, new ab}, a in the high bit
    function automatic logic signed [1:0] transition_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: d = STEP_CCW;
            4'd2, 4'd4, 4'd11, 4'd13: d = STEP_CW;
            default: d = STEP_NONE;
        endcase
        return d;
    endfunction

endpackage

### sv/rec_rot.sv
// ----------------------------------------------------------------------------
// rec_rot
// quadrature decode: lockout on a/b changes, transition table, detent counting
// ----------------------------------------------------------------------------
module rec_rot
    import rec_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tick_ctl_t         ctl,
    input  logic [1:0]        ab,
    input  logic [7:0]        detent_count,
    input  logic [7:0]        rotation_lockout,
    output logic signed [1:0] step
);

    logic [1:0]        prev_ab_reg, prev_ab_next;
    logic [1:0]        phase_reg, phase_next;
    logic signed [8:0] accum_reg, accum_next;
    logic [7:0]        elapsed_reg, elapsed_next;
    logic [7:0]        elapsed_inc;
    logic              take;
    logic signed [9:0] sum;
    logic signed [9:0] detent;

    always_comb begin
        elapsed_inc  = (elapsed_reg == ROT_ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 8'd1;
        take         = (ab != prev_ab_reg) && (elapsed_inc >= rotation_lockout);
        sum          = 10'(accum_reg) + 10'(transition_delta({phase_reg, ab}));
        detent       = $signed({2'b00, detent_count});
        prev_ab_next = prev_ab_reg;
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        elapsed_next = elapsed_reg;
        step         = STEP_NONE;
        if (ctl.first) begin
            prev_ab_next = ab;
            phase_next   = ab;
        end else begin
            prev_ab_next = ab;
            elapsed_next = elapsed_inc;
            if (take) begin
                elapsed_next = '0;
                phase_next   = ab;
                if (sum >= detent) begin
                    accum_next = '0;
                    step       = STEP_CW;
                end else if (sum <= -detent) begin
                    accum_next = '0;
                    step       = STEP_CCW;
                end else begin
                    accum_next = sum[8:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_ab_reg <= '0;
            phase_reg   <= '0;
            accum_reg   <= '0;
            elapsed_reg <= ROT_ELAPSED_MAX;
        end else if (ctl.accept) begin
            prev_ab_reg <= prev_ab_next;
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            elapsed_reg <= elapsed_next;
        end
    end

    a_step_clears_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.accept && (step != STEP_NONE) |=> (accum_reg == '0) && (elapsed_reg == '0))
        else $error("detent step without clearing accumulator and lockout");

    a_no_step_on_first: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.first |-> (step == STEP_NONE))
        else $error("step given on the priming tick");

endmodule

### sv/rec_btn.sv
// ----------------------------------------------------------------------------
// rec_btn
// switch debounce and single / double click detection
// ----------------------------------------------------------------------------
module rec_btn
    import rec_pkg::*;
#(
    parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  tick_ctl_t     ctl,
    input  logic          level_switch,
    input  logic [15:0]   debounce_time,
    input  logic [15:0]   click_window,
    output button_event_t button_event
);

    localparam int CMP_W = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;

    logic                    prev_sw_reg, prev_sw_next;
    logic                    pending_reg, pending_next;
    logic [ELAPSED_BITS-1:0] btn_elapsed_reg, btn_elapsed_next;
    logic [ELAPSED_BITS-1:0] window_reg, window_next;
    logic [ELAPSED_BITS-1:0] btn_inc, window_inc;
    logic                    pending_mid;

    always_comb begin
        btn_inc      = (&btn_elapsed_reg) ? btn_elapsed_reg
                                          : btn_elapsed_reg + ELAPSED_BITS'(1);
        window_inc   = (!pending_reg || (&window_reg)) ? window_reg
                                                       : window_reg + ELAPSED_BITS'(1);
        prev_sw_next     = prev_sw_reg;
        pending_next     = pending_reg;
        btn_elapsed_next = btn_elapsed_reg;
        window_next      = window_reg;
        pending_mid      = pending_reg;
        button_event     = EV_NONE;
        if (ctl.first) begin
            prev_sw_next = level_switch;
        end else begin
            prev_sw_next     = level_switch;
            btn_elapsed_next = btn_inc;
            window_next      = window_inc;
            // window expiry comes before the switch edge
            if (pending_reg && (CMP_W'(window_inc) >= CMP_W'(click_window))) begin
                pending_mid  = 1'b0;
                button_event = EV_SINGLE;
            end
            pending_next = pending_mid;
            if ((level_switch != prev_sw_reg)
                && (CMP_W'(btn_inc) >= CMP_W'(debounce_time))) begin
                btn_elapsed_next = '0;
                if (level_switch) begin
                    if (pending_mid) begin
                        pending_next = 1'b0;
                        button_event = EV_DOUBLE;
                    end else begin
                        pending_next = 1'b1;
                        window_next  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sw_reg     <= 1'b0;
            pending_reg     <= 1'b0;
            btn_elapsed_reg <= '1;
            window_reg      <= '0;
        end else if (ctl.accept) begin
            prev_sw_reg     <= prev_sw_next;
            pending_reg     <= pending_next;
            btn_elapsed_reg <= btn_elapsed_next;
            window_reg      <= window_next;
        end
    end

    a_double_needs_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.accept && (button_event == EV_DOUBLE) |-> pending_reg ##1 !pending_reg)
        else $error("double click without a pending click");

    a_single_ends_window: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.accept && (button_event == EV_SINGLE) |-> pending_reg)
        else $error("single click without a pending click");

endmodule

### sv/rotary_encoder_with_click.sv
// ----------------------------------------------------------------------------
// rotary_encoder_with_click
// quadrature encoder decoder with debounced push switch and double click
// ----------------------------------------------------------------------------
// Each input word is one millisecond tick of sampled a, b and switch levels.
// The block takes one word per clock and returns one result word per input
// word, in the cycle after it is taken, from the result register. A new tick is
// taken whenever the result register is empty or its word leaves in the same
// cycle, so the rate is one word per cycle as long as the result side keeps
// up; while the result side stalls, the input stalls with it. The first tick
// after reset only loads the samples and gives a zero result. The user must
// write registers through the cfg port only while no tick is in flight (unchecked).
// ----------------------------------------------------------------------------
module rotary_encoder_with_click
    import rec_pkg::*;
#(
    parameter int ELAPSED_BITS = ELAPSED_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // level_a, level_b, level_switch, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // rot_step[1:0], button_event[3:2], zero pad
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic              primed_reg;
    logic              m_tvalid_reg;
    logic [3:0]        m_tdata_reg;
    logic [7:0]        detent_count_reg;
    logic [7:0]        rotation_lockout_reg;
    logic [15:0]       debounce_time_reg;
    logic [15:0]       click_window_reg;
    tick_ctl_t         ctl;
    logic signed [1:0] rot_step;
    button_event_t     button_event;

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign ctl.accept = s_tvalid && s_tready;
    assign ctl.first  = !primed_reg;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {4'b0000, m_tdata_reg};

    rec_rot u_rot (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (ctl),
        .ab               ({s_tdata[0], s_tdata[1]}),
        .detent_count     (detent_count_reg),
        .rotation_lockout (rotation_lockout_reg),
        .step             (rot_step)
    );

    rec_btn #(
        .ELAPSED_BITS (ELAPSED_BITS)
    ) u_btn (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .level_switch  (s_tdata[2]),
        .debounce_time (debounce_time_reg),
        .click_window  (click_window_reg),
        .button_event  (button_event)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            detent_count_reg     <= DETENT_COUNT_RST;
            rotation_lockout_reg <= ROTATION_LOCKOUT_RST;
            debounce_time_reg    <= DEBOUNCE_TIME_RST;
            click_window_reg     <= CLICK_WINDOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DETENT_COUNT:     detent_count_reg     <= cfg_data[7:0];
                REG_ROTATION_LOCKOUT: rotation_lockout_reg <= cfg_data[7:0];
                REG_DEBOUNCE_TIME:    debounce_time_reg    <= cfg_data[15:0];
                REG_CLICK_WINDOW:     click_window_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ctl.accept) begin
                primed_reg   <= 1'b1;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            m_tdata_reg <= {button_event, rot_step};
        end
    end

    a_word_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.accept |=> m_tvalid_reg)
        else $error("accepted word gave no result");

    a_first_tick_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.accept && ctl.first |=> (m_tdata_reg == 4'b0000) && primed_reg)
        else $error("priming tick gave a non-zero result");

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rotary encoder with click detection
// ----------------------------------------------------------------------------
// Ticks of sampled a, b and switch levels are queued by the stimulus process
// and offered in bursts with random gaps. Each accepted word runs through
// the bench's own tick model, and its predicted rotation step and button
// event wait in order until the matching result word comes back. The result
// side stalls on a changing pattern and once holds off for a long stretch.
// Registers are rewritten between phases, once everything has drained.
// ----------------------------------------------------------------------------
module testbench;
    import rec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELAPSED_BITS = ELAPSED_BITS_DEF;
    localparam int QUIET_LIMIT  = 4000;
    localparam int LONG_HOLD    = 250;

    localparam int TURN_DELTA [16] = '{
        0, -1,  1,  0,
        1,  0,  0, -1,
       -1,  0,  0,  1,
        0,  1, -1,  0
    };

    // clockwise order of {a, b}
    localparam logic [1:0] CW_AB [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

    typedef struct packed {
        logic signed [1:0] step;
        button_event_t     ev;
    } tick_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;   // level_a, level_b, level_switch, zero pad
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;          // rot_step[1:0], button_event[3:2], zero pad
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    rotary_encoder_with_click #(
        .ELAPSED_BITS(ELAPSED_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // model configuration
    logic [7:0]  detent_cfg   = DETENT_COUNT_RST;
    logic [7:0]  lockout_cfg  = ROTATION_LOCKOUT_RST;
    logic [15:0] debounce_cfg = DEBOUNCE_TIME_RST;
    logic [15:0] window_cfg   = CLICK_WINDOW_RST;

    // model state
    logic                    primed        = 1'b0;
    logic [1:0]              prev_ab       = 2'b00;
    logic [1:0]              phase         = 2'b00;
    int                      accum         = 0;
    logic [7:0]              rot_elapsed   = ROT_ELAPSED_MAX;
    logic                    prev_sw       = 1'b0;
    logic [ELAPSED_BITS-1:0] btn_elapsed   = '1;
    logic                    click_pending = 1'b0;
    logic [ELAPSED_BITS-1:0] win_elapsed   = '0;

    logic [2:0]   pending_ticks [$];
    tick_result_t predicted_results [$];

    int error_count  = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int hold_left    = 0;
    int stall_pct    = 0;
    int rx_cycle     = 0;
    bit long_hold_done = 1'b0;

    // stimulus generator position
    int gen_pos = 0;
    int gen_dir = 1;
    bit gen_sw  = 1'b1;

    function automatic tick_result_t advance_tick(input logic [2:0] lv);
        tick_result_t res;
        logic [1:0]   ab;
        logic         sw;
        ab = {lv[0], lv[1]};
        sw = lv[2];
        res.step = STEP_NONE;
        res.ev   = EV_NONE;
        if (!primed) begin
            primed  = 1'b1;
            prev_ab = ab;
            phase   = ab;
            prev_sw = sw;
            return res;
        end
        if (rot_elapsed != ROT_ELAPSED_MAX)
            rot_elapsed++;
        if (btn_elapsed != '1)
            btn_elapsed++;
        if (click_pending && win_elapsed != '1)
            win_elapsed++;
        if (ab != prev_ab) begin
            prev_ab = ab;
            if (rot_elapsed >= lockout_cfg) begin
                rot_elapsed = '0;
                accum += TURN_DELTA[{phase, ab}];
                phase = ab;
                if (accum >= int'(detent_cfg)) begin
                    accum    = 0;
                    res.step = STEP_CW;
                end else if (accum <= -int'(detent_cfg)) begin
                    accum    = 0;
                    res.step = STEP_CCW;
                end
            end
        end
        if (click_pending && win_elapsed >= window_cfg) begin
            click_pending = 1'b0;
            res.ev        = EV_SINGLE;
        end
        if (sw != prev_sw) begin
            prev_sw = sw;
            if (btn_elapsed >= debounce_cfg) begin
                btn_elapsed = '0;
                if (sw) begin
                    if (click_pending) begin
                        click_pending = 1'b0;
                        res.ev        = EV_DOUBLE;
                    end else begin
                        click_pending = 1'b1;
                        win_elapsed   = '0;
                    end
                end
            end
        end
        return res;
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready)
                predicted_results.push_back(advance_tick(s_tdata[2:0]));
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, pending_ticks.pop_front()};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result word and drives its own stall pattern
    always @(posedge aclk) begin
        tick_result_t exp_res;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result word %h", m_tdata);
                end else begin
                    exp_res = predicted_results.pop_front();
                    if (m_tdata[1:0] !== exp_res.step || m_tdata[3:2] !== exp_res.ev) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("result %0d: step exp %0d got %0d, event exp %0d got %0d",
                                     results_seen, $signed(exp_res.step),
                                     $signed(m_tdata[1:0]), exp_res.ev, m_tdata[3:2]);
                    end
                end
            end
            rx_cycle++;
            if (rx_cycle % 50 == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            if (!long_hold_done && results_seen >= 150) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout");
                $display("testbench: errors");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_ticks.size() != 0 || s_tvalid || predicted_results.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic set_config(input int detent, input int lockout, input int debounce,
                              input int window);
        logic [15:0] vals [4];
        wait_drained();
        vals[0] = 16'(detent);
        vals[1] = 16'(lockout);
        vals[2] = 16'(debounce);
        vals[3] = 16'(window);
        for (int i = 0; i < 4; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= vals[i];
            case (cfg_reg_t'(i))
                REG_DETENT_COUNT:     detent_cfg   = vals[i][7:0];
                REG_ROTATION_LOCKOUT: lockout_cfg  = vals[i][7:0];
                REG_DEBOUNCE_TIME:    debounce_cfg = vals[i];
                REG_CLICK_WINDOW:     window_cfg   = vals[i];
                default: ;
            endcase
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
        end
        @(negedge aclk);
    endtask

    // mostly clean quadrature steps and switch toggles, some random noise words
    task automatic add_ticks(input int count, input int hold_lo, input int hold_hi,
                             input int noise_pct);
        int left;
        int hold;
        int pick;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < noise_pct) begin
                pending_ticks.push_back(3'($urandom_range(0, 7)));
                left--;
            end else begin
                if (pick < noise_pct + 55) begin
                    if ($urandom_range(0, 9) == 0)
                        gen_dir = -gen_dir;
                    gen_pos = (gen_pos + gen_dir) & 3;
                end else begin
                    gen_sw = ~gen_sw;
                end
                hold = $urandom_range(hold_lo, hold_hi);
                for (int i = 0; i < hold && left > 0; i++) begin
                    pending_ticks.push_back({gen_sw, CW_AB[gen_pos][0], CW_AB[gen_pos][1]});
                    left--;
                end
            end
        end
    endtask

    initial begin
        // words are {switch, b, a}
        logic [2:0] quick_turns [13] = '{
            3'b100, 3'b101, 3'b111, 3'b110, 3'b100, 3'b110, 3'b111,
            3'b100, 3'b000, 3'b100, 3'b100, 3'b000, 3'b100
        };
        logic [2:0] locked_turns [12] = '{
            3'b101, 3'b111, 3'b110, 3'b100, 3'b101, 3'b011,
            3'b111, 3'b011, 3'b111, 3'b111, 3'b111, 3'b111
        };
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // first tick, a full clockwise turn and steps back, a skipped phase, zero click window
        set_config(1, 0, 0, 0);
        foreach (quick_turns[i])
            pending_ticks.push_back(quick_turns[i]);
        // zero detent count, ignored edges, bouncing switch
        set_config(0, 3, 2, 2);
        foreach (locked_turns[i])
            pending_ticks.push_back(locked_turns[i]);

        set_config(DETENT_COUNT_RST, ROTATION_LOCKOUT_RST, DEBOUNCE_TIME_RST,
                   CLICK_WINDOW_RST);
        add_ticks(100, 1, 30, 5);
        set_config(1, 0, 0, 1);
        add_ticks(100, 1, 4, 10);
        set_config(255, 1, 3, 10);
        add_ticks(80, 1, 5, 8);
        repeat (3) begin
            set_config($urandom_range(1, 8), $urandom_range(0, 4), $urandom_range(0, 8),
                       $urandom_range(1, 40));
            add_ticks(70, 1, 8, 8);
        end
        set_config(2, 0, 65535, 65535);
        add_ticks(50, 1, 6, 5);
        // long holds let the rotation counter saturate
        set_config(0, 255, 0, 0);
        add_ticks(520, 240, 260, 0);

        wait_drained();
        repeat (20) @(negedge aclk);
        if (predicted_results.size() != 0) begin
            error_count++;
            $display("%0d results never arrived", predicted_results.size());
        end
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

### filelist.f
sv/rec_pkg.sv
sv/rec_rot.sv
sv/rec_btn.sv
sv/rotary_encoder_with_click.sv
verif/testbench.sv
